/* rtl/core/tmn_pkg.sv */
// ----------------------------------------------------------------------------
// tmn_pkg
// Shared types and constants of the ticket mutex node: sizes, command and
// message codes, and the control and status bundles between the FSM and the
// datapath.
// ----------------------------------------------------------------------------
package tmn_pkg;

  localparam int NODES    = 3;
  localparam int ID_W     = 4;
  localparam int CMD_W    = 2;
  localparam int KIND_W   = 2;
  localparam int OFFSET_W = 10;
  localparam int TICKET_W = 32;
  localparam int CNT_W    = $clog2(NODES);
  localparam int QDEPTH   = NODES - 1;
  localparam int QIDX_W   = (NODES > 2) ? $clog2(NODES - 1) : 1;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'(999);
  localparam logic [TICKET_W-1:0] TICKET_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_ENTER    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXIT     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEER_REQ = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PEER_REP = 2'd3;

  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd2;

  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_NODE_ID = 1'b0;

  typedef enum logic [1:0] {
    SRC_REQUEST,
    SRC_QUEUE,
    SRC_PEER,
    SRC_GRANT
  } tmn_src_e;

  typedef struct packed {
    logic     item_load;
    logic     do_enter;
    logic     do_exit;
    logic     do_peer_req;
    logic     do_peer_rep;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     clr_deferred;
    logic     out_load;
    logic     out_last;
    tmn_src_e out_src;
  } tmn_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             enter_ok;
    logic             peer_reply;
    logic             grant_now;
    logic             deferred_empty;
    logic             last_request;
    logic             last_queued;
    logic             out_free;
  } tmn_status_t;

endpackage

/* rtl/core/ticket_mutex_node.sv */
// ----------------------------------------------------------------------------
// ticket_mutex_node
// One node of ticket-based distributed mutual exclusion with its node id
// register on an APB-style port.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------
//   input    | in        | in_valid_i/in_ready_o | cmd, rand_offset, peer_ticket,
//            |           |                       | peer_id
//   output   | out       | out_valid_o/out_ready_i | msg_kind, dest_id, msg_ticket,
//            |           |                       | last
//   config   | in/out    | psel/penable/pready   | paddr, pwdata, prdata
//
// A request is taken in the idle state and decided in the cycle after.  It
// causes NODES-1 messages on an accepted enter, one per deferred peer on exit
// and at most one otherwise.  The sequencer handles one request at a time;
// the output register lets it take the next request while the last message
// waits.  Reset clears all control state; a stalled output holds the sequencer
// in its sending state.
module ticket_mutex_node
  import tmn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [OFFSET_W-1:0] rand_offset_i,
  input  logic [TICKET_W-1:0] peer_ticket_i,
  input  logic [ID_W-1:0]     peer_id_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KIND_W-1:0]   msg_kind_o,
  output logic [ID_W-1:0]     dest_id_o,
  output logic [TICKET_W-1:0] msg_ticket_o,
  output logic                last_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [ID_W-1:0] node_id_q;
  tmn_ctrl_t       ctrl;
  tmn_status_t     status;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_NODE_ID)) begin
      node_id_q <= pwdata[ID_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_NODE_ID) ? 32'(node_id_q) : '0;

  tmn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  tmn_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .node_id_i     (node_id_q),
    .cmd_i         (cmd_i),
    .rand_offset_i (rand_offset_i),
    .peer_ticket_i (peer_ticket_i),
    .peer_id_i     (peer_id_i),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .msg_kind_o    (msg_kind_o),
    .dest_id_o     (dest_id_o),
    .msg_ticket_o  (msg_ticket_o),
    .last_o        (last_o)
  );

endmodule

/* rtl/core/tmn_ctrl.sv */
// ----------------------------------------------------------------------------
// tmn_ctrl
// Sequencer of the ticket mutex node: takes a request, lets the datapath
// decide on it and steps through the resulting messages.
// ----------------------------------------------------------------------------
module tmn_ctrl
  import tmn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  tmn_status_t status_i,
  output tmn_ctrl_t   ctrl_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_REQ   = 3'd2;
  localparam logic [2:0] S_REP   = 3'd3;
  localparam logic [2:0] S_REPLY = 3'd4;
  localparam logic [2:0] S_GRANT = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.item_load = 1'b1;
          state_d          = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status_i.cmd)
          CMD_ENTER: begin
            if (status_i.enter_ok) begin
              ctrl_o.do_enter = 1'b1;
              ctrl_o.cnt_clr  = 1'b1;
              state_d         = S_REQ;
            end else begin
              state_d = S_IDLE;
            end
          end
          CMD_EXIT: begin
            ctrl_o.do_exit = 1'b1;
            ctrl_o.cnt_clr = 1'b1;
            state_d        = status_i.deferred_empty ? S_IDLE : S_REP;
          end
          CMD_PEER_REQ: begin
            ctrl_o.do_peer_req = 1'b1;
            state_d            = status_i.peer_reply ? S_REPLY : S_IDLE;
          end
          CMD_PEER_REP: begin
            ctrl_o.do_peer_rep = 1'b1;
            state_d            = status_i.grant_now ? S_GRANT : S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_REQ: begin
        ctrl_o.out_src  = SRC_REQUEST;
        ctrl_o.out_last = status_i.last_request;
        if (status_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.cnt_inc  = 1'b1;
          if (status_i.last_request) begin
            state_d = S_IDLE;
          end
        end
      end
      S_REP: begin
        ctrl_o.out_src  = SRC_QUEUE;
        ctrl_o.out_last = status_i.last_queued;
        if (status_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          ctrl_o.cnt_inc  = 1'b1;
          if (status_i.last_queued) begin
            ctrl_o.clr_deferred = 1'b1;
            state_d             = S_IDLE;
          end
        end
      end
      S_REPLY: begin
        ctrl_o.out_src  = SRC_PEER;
        ctrl_o.out_last = 1'b1;
        if (status_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_GRANT: begin
        ctrl_o.out_src  = SRC_GRANT;
        ctrl_o.out_last = 1'b1;
        if (status_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/tmn_dpath.sv */
// ----------------------------------------------------------------------------
// tmn_dpath
// Datapath of the ticket mutex node: request registers, ticket arithmetic,
// deferred queue, message counter and the output register.
// ----------------------------------------------------------------------------
module tmn_dpath
  import tmn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ID_W-1:0]     node_id_i,
  input  logic [CMD_W-1:0]    cmd_i,
  input  logic [OFFSET_W-1:0] rand_offset_i,
  input  logic [TICKET_W-1:0] peer_ticket_i,
  input  logic [ID_W-1:0]     peer_id_i,
  input  tmn_ctrl_t           ctrl_i,
  output tmn_status_t         status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [KIND_W-1:0]   msg_kind_o,
  output logic [ID_W-1:0]     dest_id_o,
  output logic [TICKET_W-1:0] msg_ticket_o,
  output logic                last_o
);

  logic [CMD_W-1:0]    cmd_q;
  logic [OFFSET_W-1:0] offset_q;
  logic [TICKET_W-1:0] pticket_q;
  logic [ID_W-1:0]     pid_q;

  logic                wanting_q;
  logic [TICKET_W-1:0] own_ticket_q, highest_q;
  logic [ID_W-1:0]     reply_cnt_q;
  logic [CNT_W-1:0]    defer_cnt_q;
  logic [ID_W-1:0]     defer_q [QDEPTH];
  logic [CNT_W-1:0]    cnt_q;

  logic                out_valid_q, last_q;
  logic [KIND_W-1:0]   kind_q;
  logic [ID_W-1:0]     dest_q;
  logic [TICKET_W-1:0] ticket_q;

  logic [OFFSET_W-1:0] offset_sat;
  logic [TICKET_W:0]   ticket_sum;
  logic [TICKET_W-1:0] new_ticket;
  logic                peer_reply;
  logic [ID_W-1:0]     reply_next;
  logic                grant_now;
  logic [ID_W-1:0]     cnt_ext, req_dest;
  logic                out_free;
  logic [KIND_W-1:0]   kind_d;
  logic [ID_W-1:0]     dest_d;
  logic [TICKET_W-1:0] ticket_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.item_load) begin
      cmd_q     <= cmd_i;
      offset_q  <= rand_offset_i;
      pticket_q <= peer_ticket_i;
      pid_q     <= peer_id_i;
    end
  end

  assign offset_sat = (offset_q > OFFSET_MAX) ? OFFSET_MAX : offset_q;
  assign ticket_sum = {1'b0, highest_q} + (TICKET_W + 1)'(offset_sat);
  assign new_ticket = ticket_sum[TICKET_W] ? TICKET_MAX : ticket_sum[TICKET_W-1:0];

  assign peer_reply = !wanting_q || (pticket_q < own_ticket_q) ||
                      ((pticket_q == own_ticket_q) && (pid_q < node_id_i));

  assign reply_next = reply_cnt_q + ID_W'(1);
  assign grant_now  = wanting_q && (reply_next == ID_W'(NODES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanting_q    <= 1'b0;
      own_ticket_q <= '0;
      highest_q    <= '0;
      reply_cnt_q  <= '0;
      defer_cnt_q  <= '0;
      cnt_q        <= '0;
    end else begin
      if (ctrl_i.do_enter) begin
        wanting_q    <= 1'b1;
        own_ticket_q <= new_ticket;
        reply_cnt_q  <= '0;
      end
      if (ctrl_i.do_exit) begin
        wanting_q <= 1'b0;
      end
      if (ctrl_i.do_peer_req) begin
        if (peer_reply) begin
          if (pticket_q > highest_q) begin
            highest_q <= pticket_q;
          end
        end else if (defer_cnt_q < CNT_W'(QDEPTH)) begin
          defer_cnt_q <= defer_cnt_q + CNT_W'(1);
        end
      end
      if (ctrl_i.do_peer_rep && wanting_q) begin
        reply_cnt_q <= grant_now ? '0 : reply_next;
      end
      if (ctrl_i.clr_deferred) begin
        defer_cnt_q <= '0;
      end
      if (ctrl_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (ctrl_i.cnt_inc) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.do_peer_req && !peer_reply && (defer_cnt_q < CNT_W'(QDEPTH))) begin
      defer_q[defer_cnt_q[QIDX_W-1:0]] <= pid_q;
    end
  end

  assign cnt_ext  = ID_W'(cnt_q);
  assign req_dest = (cnt_ext < node_id_i) ? cnt_ext : cnt_ext + ID_W'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    kind_d   = KIND_GRANT;
    dest_d   = '0;
    ticket_d = '0;
    case (ctrl_i.out_src)
      SRC_REQUEST: begin
        kind_d   = KIND_REQUEST;
        dest_d   = req_dest;
        ticket_d = own_ticket_q;
      end
      SRC_QUEUE: begin
        kind_d = KIND_REPLY;
        dest_d = defer_q[cnt_q[QIDX_W-1:0]];
      end
      SRC_PEER: begin
        kind_d = KIND_REPLY;
        dest_d = pid_q;
      end
      SRC_GRANT: begin
        kind_d = KIND_GRANT;
      end
      default: kind_d = KIND_GRANT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      kind_q   <= kind_d;
      dest_q   <= dest_d;
      ticket_q <= ticket_d;
      last_q   <= ctrl_i.out_last;
    end
  end

  assign status_o.cmd            = cmd_q;
  assign status_o.enter_ok       = !wanting_q;
  assign status_o.peer_reply     = peer_reply;
  assign status_o.grant_now      = grant_now;
  assign status_o.deferred_empty = (defer_cnt_q == '0);
  assign status_o.last_request   = (cnt_q == CNT_W'(NODES - 2));
  assign status_o.last_queued    = (cnt_q == defer_cnt_q - CNT_W'(1));
  assign status_o.out_free       = out_free;

  assign out_valid_o  = out_valid_q;
  assign msg_kind_o   = kind_q;
  assign dest_id_o    = dest_q;
  assign msg_ticket_o = ticket_q;
  assign last_o       = last_q;

endmodule

/* rtl/core/tmn_checker.sv */
// ----------------------------------------------------------------------------
// tmn_checker
// Port-level checks of the ticket mutex node, bound to the top level.
// ----------------------------------------------------------------------------
module tmn_checker
  import tmn_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [KIND_W-1:0]   msg_kind_o,
  input logic [ID_W-1:0]     dest_id_o,
  input logic [TICKET_W-1:0] msg_ticket_o,
  input logic                last_o,
  input logic                pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(msg_kind_o) && $stable(dest_id_o))
    else $error("Output request dropped or changed while stalled.");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (msg_kind_o == KIND_REQUEST) || (msg_kind_o == KIND_REPLY) ||
                    (msg_kind_o == KIND_GRANT))
    else $error("Illegal message kind.");

  a_grant_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (msg_kind_o == KIND_GRANT) |->
      (dest_id_o == '0) && (msg_ticket_o == '0) && last_o)
    else $error("Grant carries a destination, a ticket or is not last.");

  a_reply_ticket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (msg_kind_o == KIND_REPLY) |-> (msg_ticket_o == '0))
    else $error("Reply carries a ticket.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("Configuration port inserted a wait state.");

endmodule

bind ticket_mutex_node tmn_checker u_tmn_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .msg_kind_o   (msg_kind_o),
  .dest_id_o    (dest_id_o),
  .msg_ticket_o (msg_ticket_o),
  .last_o       (last_o),
  .pready       (pready)
);

/* tb/ticket_mutex_node_test.sv */
// ----------------------------------------------------------------------------
// ticket_mutex_node_test
// Drives requests into one ticket mutex node and checks every message that
// it sends against a predictor of the node's behavior, or on some rows of a
// short table of directed requests against fixed messages. The table covers
// the corner cases, and random protocol traffic runs in its middle under
// several node ids. Both sides idle and stall at random.
module ticket_mutex_node_test;
  import tmn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 2 * NODES + 6;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 88;
  localparam int SCRIPT_LEN    = 32;
  localparam logic [1:0] FROM_PREDICTOR = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     dest;
    logic [TICKET_W-1:0] ticket;
    logic                is_last;
  } node_msg_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_CFG,
    ROW_RANDOM
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CMD_W-1:0]    cmd;
    logic [OFFSET_W-1:0] offset;
    logic [TICKET_W-1:0] ticket;
    logic [ID_W-1:0]     peer;
    logic [1:0]          fixed_n;
    node_msg_t           fixed_msg;
  } script_row_t;

  localparam node_msg_t NO_MSG    = '0;
  localparam node_msg_t GRANT_MSG = '{KIND_GRANT, 4'd0, 32'd0, 1'b0};

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CMD_W-1:0]    cmd_i;
  logic [OFFSET_W-1:0] rand_offset_i;
  logic [TICKET_W-1:0] peer_ticket_i;
  logic [ID_W-1:0]     peer_id_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [KIND_W-1:0]   msg_kind_o;
  logic [ID_W-1:0]     dest_id_o;
  logic [TICKET_W-1:0] msg_ticket_o;
  logic                last_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  ticket_mutex_node dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .rand_offset_i (rand_offset_i),
    .peer_ticket_i (peer_ticket_i),
    .peer_id_i     (peer_id_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .msg_kind_o    (msg_kind_o),
    .dest_id_o     (dest_id_o),
    .msg_ticket_o  (msg_ticket_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predicted node state.
  logic [ID_W-1:0]     node_id_shadow;
  logic                wanting;
  logic [TICKET_W-1:0] own_ticket;
  logic [TICKET_W-1:0] highest_seen;
  logic [3:0]          reply_count;
  logic [ID_W-1:0]     deferred_ids [NODES-1];
  int                  deferred_count;

  node_msg_t expected_msgs [$];
  node_msg_t oldest_msg;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  int        burst_left = 1;
  int        gap_left = 0;
  bit        holding_valid = 0;

  int        stall_mode = 0;
  int        stall_span = 0;
  logic [7:0] stall_bits = 8'hFF;

  script_row_t script [SCRIPT_LEN] = '{
    '{ROW_ITEM, CMD_PEER_REP, 10'd0, 32'd0, 4'd0, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_EXIT, 10'd0, 32'd0, 4'd0, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'd0, 4'd0, 2'd1, '{KIND_REPLY, 4'd0, 32'd0, 1'b0}},
    '{ROW_ITEM, CMD_ENTER, 10'd0, 32'd0, 4'd0, FROM_PREDICTOR, NO_MSG},
    '{ROW_ITEM, CMD_ENTER, 10'd1023, 32'd0, 4'd0, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'd0, 4'd0, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'hFFFF_FFFF, 4'd15, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'hFFFF_FFFF, 4'd1, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REP, 10'd0, 32'd0, 4'd1, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REP, 10'd0, 32'd0, 4'd2, 2'd1, GRANT_MSG},
    '{ROW_ITEM, CMD_EXIT, 10'd0, 32'd0, 4'd0, FROM_PREDICTOR, NO_MSG},
    '{ROW_CFG, CMD_ENTER, 10'd0, 32'd15, 4'd0, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_ENTER, 10'd1023, 32'd0, 4'd0, FROM_PREDICTOR, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'd999, 4'd2, 2'd1, '{KIND_REPLY, 4'd2, 32'd0, 1'b0}},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'd998, 4'd14, 2'd1,
      '{KIND_REPLY, 4'd14, 32'd0, 1'b0}},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'd1000, 4'd0, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_EXIT, 10'd0, 32'd0, 4'd0, FROM_PREDICTOR, NO_MSG},
    '{ROW_CFG, CMD_ENTER, 10'd0, 32'd1, 4'd0, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_ENTER, 10'd5, 32'd0, 4'd0, FROM_PREDICTOR, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'd1004, 4'd0, 2'd1,
      '{KIND_REPLY, 4'd0, 32'd0, 1'b0}},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'd1004, 4'd2, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REP, 10'd0, 32'd0, 4'd0, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REP, 10'd0, 32'd0, 4'd2, 2'd1, GRANT_MSG},
    '{ROW_ITEM, CMD_EXIT, 10'd0, 32'd0, 4'd0, FROM_PREDICTOR, NO_MSG},
    '{ROW_RANDOM, CMD_ENTER, 10'd0, 32'd0, 4'd0, 2'd0, NO_MSG},
    '{ROW_CFG, CMD_ENTER, 10'd0, 32'd2, 4'd0, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_EXIT, 10'd0, 32'd0, 4'd0, FROM_PREDICTOR, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'hFFFF_FFFE, 4'd7, 2'd1,
      '{KIND_REPLY, 4'd7, 32'd0, 1'b0}},
    '{ROW_ITEM, CMD_ENTER, 10'd999, 32'd0, 4'd0, FROM_PREDICTOR, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'hFFFF_FFFF, 4'd3, 2'd0, NO_MSG},
    '{ROW_ITEM, CMD_PEER_REQ, 10'd0, 32'hFFFF_FFFF, 4'd1, 2'd1,
      '{KIND_REPLY, 4'd1, 32'd0, 1'b0}},
    '{ROW_ITEM, CMD_EXIT, 10'd0, 32'd0, 4'd0, FROM_PREDICTOR, NO_MSG}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void queue_msg(input logic [KIND_W-1:0] kind,
                                    input logic [ID_W-1:0] dest,
                                    input logic [TICKET_W-1:0] ticket);
    node_msg_t m;
    m = '{kind, dest, ticket, 1'b0};
    expected_msgs.push_back(m);
  endfunction

  // Advances the predicted node state by one request and queues the
  // messages that the request causes.
  function automatic void predict_messages(input logic [CMD_W-1:0] cmd,
                                           input logic [OFFSET_W-1:0] offset,
                                           input logic [TICKET_W-1:0] ticket,
                                           input logic [ID_W-1:0] peer);
    int                  base;
    int                  sent;
    logic [OFFSET_W-1:0] step;
    logic                answer;
    base = expected_msgs.size();
    case (cmd)
      CMD_ENTER: begin
        if (!wanting) begin
          step = (offset > OFFSET_MAX) ? OFFSET_MAX : offset;
          if (highest_seen > TICKET_MAX - TICKET_W'(step)) begin
            own_ticket = TICKET_MAX;
          end else begin
            own_ticket = highest_seen + TICKET_W'(step);
          end
          wanting = 1'b1;
          reply_count = '0;
          sent = 0;
          for (int i = 0; i < NODES && sent < NODES - 1; i++) begin
            if (i != int'(node_id_shadow)) begin
              queue_msg(KIND_REQUEST, ID_W'(i), own_ticket);
              sent++;
            end
          end
        end
      end
      CMD_EXIT: begin
        wanting = 1'b0;
        for (int i = 0; i < deferred_count && i < NODES - 1; i++) begin
          queue_msg(KIND_REPLY, deferred_ids[i], '0);
        end
        deferred_count = 0;
      end
      CMD_PEER_REQ: begin
        answer = !wanting || ticket < own_ticket ||
                 (ticket == own_ticket && peer < node_id_shadow);
        if (answer) begin
          if (ticket > highest_seen) begin
            highest_seen = ticket;
          end
          queue_msg(KIND_REPLY, peer, '0);
        end else if (deferred_count < NODES - 1) begin
          deferred_ids[deferred_count] = peer;
          deferred_count++;
        end
      end
      default: begin
        if (wanting) begin
          reply_count = reply_count + 4'd1;
          if (reply_count == 4'(NODES - 1)) begin
            reply_count = '0;
            queue_msg(KIND_GRANT, '0, '0);
          end
        end
      end
    endcase
    if (expected_msgs.size() > base) begin
      expected_msgs[expected_msgs.size() - 1].is_last = 1'b1;
    end
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd,
                              input logic [OFFSET_W-1:0] offset,
                              input logic [TICKET_W-1:0] ticket,
                              input logic [ID_W-1:0] peer);
    repeat (gap_left) @(posedge clk_i);
    gap_left = 0;
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    rand_offset_i <= offset;
    peer_ticket_i <= ticket;
    peer_id_i     <= peer;
    holding_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
    end
    if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      holding_valid = 1'b0;
    end
  endtask

  task automatic wait_drained();
    if (holding_valid) begin
      in_valid_i <= 1'b0;
      holding_valid = 1'b0;
    end
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the node id and reads it back over the register port.
  task automatic write_node_id(input logic [ID_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({REG_NODE_ID, 2'b00});
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    node_id_shadow = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      mismatch_count++;
      $display("%0t: node_id readback expected %0d actual %0d", $time, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random_traffic();
    logic [CMD_W-1:0]    cmd;
    logic [OFFSET_W-1:0] offset;
    logic [TICKET_W-1:0] ticket;
    logic [ID_W-1:0]     peer;
    logic [TICKET_W:0]   sum;
    int                  pick;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: write_node_id(4'd15);
        1: write_node_id(4'd2);
        2: write_node_id(4'd0);
        3: write_node_id(4'd1);
        default: write_node_id(ID_W'($urandom_range(0, 15)));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (wanting) begin
          cmd = (pick < 5) ? CMD_ENTER : (pick < 20) ? CMD_EXIT :
                (pick < 60) ? CMD_PEER_REP : CMD_PEER_REQ;
        end else begin
          cmd = (pick < 40) ? CMD_ENTER : (pick < 45) ? CMD_EXIT :
                (pick < 55) ? CMD_PEER_REP : CMD_PEER_REQ;
        end
        if ($urandom_range(0, 9) == 0) begin
          offset = OFFSET_W'(1023 - $urandom_range(0, 24));
        end else begin
          offset = OFFSET_W'($urandom_range(0, 999));
        end
        if (wanting) begin
          case ($urandom_range(0, 3))
            0: ticket = $urandom;
            1: ticket = own_ticket;
            2: ticket = own_ticket - TICKET_W'($urandom_range(0, 3));
            default: ticket = own_ticket + TICKET_W'($urandom_range(1, 3));
          endcase
        end else begin
          sum = {1'b0, highest_seen} + (TICKET_W + 1)'($urandom_range(0, 3000));
          ticket = sum[TICKET_W] ? TICKET_MAX : sum[TICKET_W-1:0];
        end
        if ($urandom_range(0, 1) == 0) begin
          peer = ID_W'($urandom_range(0, NODES));
        end else begin
          peer = ID_W'($urandom_range(0, 15));
        end
        predict_messages(cmd, offset, ticket, peer);
        send_request(cmd, offset, ticket, peer);
      end
    end
  endtask

  initial begin
    int        depth;
    node_msg_t fixed;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    cmd_i         <= CMD_ENTER;
    rand_offset_i <= '0;
    peer_ticket_i <= '0;
    peer_id_i     <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    node_id_shadow = '0;
    wanting        = 1'b0;
    own_ticket     = '0;
    highest_seen   = '0;
    reply_count    = '0;
    deferred_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      case (script[r].kind)
        ROW_CFG: begin
          wait_drained();
          write_node_id(script[r].ticket[ID_W-1:0]);
        end
        ROW_RANDOM: begin
          run_random_traffic();
          wait_drained();
        end
        default: begin
          depth = expected_msgs.size();
          predict_messages(script[r].cmd, script[r].offset, script[r].ticket,
                           script[r].peer);
          if (script[r].fixed_n != FROM_PREDICTOR) begin
            while (expected_msgs.size() > depth) expected_msgs.pop_back();
            if (script[r].fixed_n == 2'd1) begin
              fixed = script[r].fixed_msg;
              fixed.is_last = 1'b1;
              expected_msgs.push_back(fixed);
            end
          end
          send_request(script[r].cmd, script[r].offset, script[r].ticket,
                       script[r].peer);
        end
      endcase
    end
    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_msgs.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected message kind %0d dest %0d ticket %h last %0d",
                 $time, msg_kind_o, dest_id_o, msg_ticket_o, last_o);
      end else begin
        oldest_msg = expected_msgs.pop_front();
        if (msg_kind_o !== oldest_msg.kind) begin
          mismatch_count++;
          $display("%0t: msg_kind expected %0d actual %0d", $time, oldest_msg.kind,
                   msg_kind_o);
        end
        if (dest_id_o !== oldest_msg.dest) begin
          mismatch_count++;
          $display("%0t: dest_id expected %0d actual %0d", $time, oldest_msg.dest,
                   dest_id_o);
        end
        if (msg_ticket_o !== oldest_msg.ticket) begin
          mismatch_count++;
          $display("%0t: msg_ticket expected %h actual %h", $time, oldest_msg.ticket,
                   msg_ticket_o);
        end
        if (last_o !== oldest_msg.is_last) begin
          mismatch_count++;
          $display("%0t: last expected %0d actual %0d", $time, oldest_msg.is_last,
                   last_o);
        end
      end
    end
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_span = $urandom_range(8, 80);
      stall_bits = 8'($urandom) | 8'd1;
    end else begin
      stall_span--;
    end
    stall_bits = {stall_bits[6:0], stall_bits[7]};
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= stall_bits[0];
      default: out_ready_i <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
